// ===== sv/igrp_pkg.sv =====
// Package with the request payload types and constants of the IGRP metric combiner.
package igrp_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] REG_WEIGHT_BW    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_WEIGHT_LOAD  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_WEIGHT_DELAY = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_REL_OFFSET   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_REL_SCALE    = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_UNREACH      = 3'd5;

    localparam logic [8:0] LOAD_BASE = 9'd256;

    typedef struct packed {
        logic [23:0] adv_delay;
        logic [23:0] adv_bandwidth;
        logic [15:0] adv_mtu;
        logic [7:0]  adv_reliability;
        logic [7:0]  adv_load;
        logic [7:0]  adv_hops;
        logic        iface_present;
        logic [23:0] iface_delay;
        logic [23:0] iface_bandwidth;
        logic [15:0] iface_mtu;
        logic [7:0]  iface_reliability;
        logic [7:0]  iface_load;
    } t_in;

    typedef struct packed {
        logic [31:0] composite_metric;
        logic        unreachable;
        logic [24:0] path_delay;
        logic [23:0] path_bandwidth;
        logic [15:0] path_mtu;
        logic [7:0]  path_reliability;
        logic [7:0]  path_load;
        logic [7:0]  path_hops;
    } t_out;

endpackage

// ===== sv/igrp_metric_combine_core.sv =====
// Top level of the IGRP route metric combiner pipeline.
// Each request merges an advertised route vector with an optional interface vector and
// computes the K1..K5 composite metric. It is a stall-all pipeline taking one request every
// cycle unless the output stalls; two 32-stage pipelined dividers (load and reliability
// terms) plus merge, multiply and sum stages set its depth. One result per request, in
// order. Configuration must be written only while the pipeline is empty; not enforced.
module igrp_metric_combine_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  igrp_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output igrp_pkg::t_out                o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [igrp_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    import igrp_pkg::*;

    localparam int unsigned Depth = 69;

    logic [7:0]  r_k1, r_k2, r_k3, r_k4, r_k5;
    logic [31:0] r_unreach;
    logic        w_en;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1 <= 8'd1; r_k2 <= '0; r_k3 <= 8'd1; r_k4 <= '0; r_k5 <= '0;
            r_unreach <= '1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WEIGHT_BW:    r_k1 <= i_cfg_data[7:0];
                REG_WEIGHT_LOAD:  r_k2 <= i_cfg_data[7:0];
                REG_WEIGHT_DELAY: r_k3 <= i_cfg_data[7:0];
                REG_REL_OFFSET:   r_k4 <= i_cfg_data[7:0];
                REG_REL_SCALE:    r_k5 <= i_cfg_data[7:0];
                REG_UNREACH:      r_unreach <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Whole pipeline advances together unless the last stage holds a refused result.
    logic [Depth-1:0] r_vld;
    assign w_en       = !(o_out_valid && !i_out_ready);
    assign o_in_ready = w_en;
    assign o_out_valid = r_vld[Depth-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[Depth-2:0], i_in_valid};
    end

    // Stage 1: merge the vectors.
    t_out r_s1;
    logic r_s1_big;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1.composite_metric <= '0;
            r_s1.unreachable      <= 1'b0;
            r_s1_big <= {8'd0, i_in_data.adv_delay} >= r_unreach;
            if (i_in_data.iface_present) begin
                r_s1.path_delay <= {1'b0, i_in_data.adv_delay} + {1'b0, i_in_data.iface_delay};
                r_s1.path_bandwidth <= (i_in_data.adv_bandwidth > i_in_data.iface_bandwidth)
                    ? i_in_data.adv_bandwidth : i_in_data.iface_bandwidth;
                r_s1.path_mtu <= (i_in_data.adv_mtu < i_in_data.iface_mtu)
                    ? i_in_data.adv_mtu : i_in_data.iface_mtu;
                r_s1.path_reliability <= (i_in_data.adv_reliability != 0 &&
                    i_in_data.adv_reliability < i_in_data.iface_reliability)
                    ? i_in_data.adv_reliability : i_in_data.iface_reliability;
                r_s1.path_load <= (i_in_data.adv_load != 0 &&
                    i_in_data.adv_load > i_in_data.iface_load)
                    ? i_in_data.adv_load : i_in_data.iface_load;
                r_s1.path_hops <= i_in_data.adv_hops + 8'd1;
            end else begin
                r_s1.path_delay       <= {1'b0, i_in_data.adv_delay};
                r_s1.path_bandwidth   <= i_in_data.adv_bandwidth;
                r_s1.path_mtu         <= i_in_data.adv_mtu;
                r_s1.path_reliability <= i_in_data.adv_reliability;
                r_s1.path_load        <= i_in_data.adv_load;
                r_s1.path_hops        <= i_in_data.adv_hops;
            end
        end
    end

    // Stage 2: weighted products; a zero weight gives a zero product anyway.
    logic [31:0] r_p1, r_p2, r_p3;
    logic [8:0]  r_lden;
    t_out r_s2;
    logic r_s2_big;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1 <= 32'({r_s1.path_bandwidth} * {r_k1});
            r_p2 <= 32'({r_s1.path_bandwidth} * {r_k2});
            r_p3 <= 32'({r_s1.path_delay} * {r_k3});
            r_lden <= LOAD_BASE - {1'b0, r_s1.path_load};
            r_s2 <= r_s1;
            r_s2_big <= r_s1_big;
        end
    end

    // Load term divider with matching delay line for the rest.
    logic [31:0] w_q2;
    igrp_div u_div_load (.i_clk(i_clk), .i_en(w_en), .i_num(r_p2), .i_den(r_lden),
                         .o_quo(w_q2));

    t_out        r_d1 [0:31];
    logic [31:0] r_d1_m [0:31];
    logic        r_d1_big [0:31];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d1[0] <= r_s2; r_d1_m[0] <= r_p1 + r_p3; r_d1_big[0] <= r_s2_big;
            for (int i = 1; i < 32; i++) begin
                r_d1[i] <= r_d1[i-1]; r_d1_m[i] <= r_d1_m[i-1]; r_d1_big[i] <= r_d1_big[i-1];
            end
        end
    end

    // Stage: sum, then scale and reliability divisor.
    logic [31:0] r_sum;
    t_out r_s3;
    logic r_s3_big;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum <= r_d1_m[31] + w_q2;
            r_s3 <= r_d1[31];
            r_s3_big <= r_d1_big[31];
        end
    end

    logic [31:0] r_scaled, r_sum4;
    logic [8:0]  r_rden;
    t_out r_s4;
    logic r_s4_big;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_scaled <= 32'(r_sum * {24'd0, r_k5});
            r_sum4 <= r_sum;
            r_rden <= {1'b0, r_s3.path_reliability} + {1'b0, r_k4};
            r_s4 <= r_s3;
            r_s4_big <= r_s3_big;
        end
    end

    logic [31:0] w_q5;
    igrp_div u_div_rel (.i_clk(i_clk), .i_en(w_en), .i_num(r_scaled), .i_den(r_rden),
                        .o_quo(w_q5));

    t_out        r_d2 [0:31];
    logic [31:0] r_d2_m [0:31];
    logic        r_d2_big [0:31];
    logic        r_d2_z [0:31];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d2[0] <= r_s4; r_d2_m[0] <= r_sum4; r_d2_big[0] <= r_s4_big;
            r_d2_z[0] <= (r_rden == '0);
            for (int i = 1; i < 32; i++) begin
                r_d2[i] <= r_d2[i-1]; r_d2_m[i] <= r_d2_m[i-1];
                r_d2_big[i] <= r_d2_big[i-1]; r_d2_z[i] <= r_d2_z[i-1];
            end
        end
    end

    // Output stage: pick the final metric and flag.
    t_out r_out;
    t_out n_out;
    always_comb begin
        n_out = r_d2[31];
        if (r_d2_big[31] || (r_k5 != 0 && r_d2_z[31])) begin
            n_out.composite_metric = r_unreach;
            n_out.unreachable      = 1'b1;
        end else begin
            n_out.composite_metric = (r_k5 != 0) ? w_q5 : r_d2_m[31];
            n_out.unreachable      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end
    assign o_out_data = r_out;

    // A held result must not change while refused.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data) && o_out_valid)
        else $error("result changed while stalled");
    // A stall must freeze the pipeline occupancy.
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |=> $stable(r_vld))
        else $error("pipeline moved during stall");
    // The flag always comes with the unreachable level as metric.
    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.unreachable |-> o_out_data.composite_metric == r_unreach)
        else $error("flag without unreachable metric");
endmodule

// ===== sv/igrp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module igrp_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_num,
    input  logic [8:0]  i_den,
    output logic [31:0] o_quo
);
    logic [31:0] r_q   [1:32];
    logic [8:0]  r_rem [1:31];
    logic [8:0]  r_den [1:31];

    // Each stage shifts in one numerator bit and tries a subtraction.
    for (genvar s = 0; s < 32; s++) begin : g_st
        logic [31:0] w_qi;
        logic [8:0]  w_ri;
        logic [8:0]  w_di;
        logic [9:0]  w_t;
        logic [9:0]  w_d;

        // The first stage takes its operands straight from the ports.
        if (s == 0) begin : g_in
            assign w_qi = i_num;
            assign w_ri = '0;
            assign w_di = i_den;
        end else begin : g_mid
            assign w_qi = r_q[s];
            assign w_ri = r_rem[s];
            assign w_di = r_den[s];
        end

        assign w_t = {w_ri, w_qi[31]};
        assign w_d = w_t - {1'b0, w_di};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s+1] <= {w_qi[30:0], !w_d[9]};
            end
        end

        // The last stage only needs the quotient.
        if (s < 31) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[s+1] <= w_di;
                    r_rem[s+1] <= w_d[9] ? w_t[8:0] : w_d[8:0];
                end
            end
        end
    end

    assign o_quo = r_q[32];
endmodule

// ===== tb/igrp_metric_checker.sv =====
// Checker that predicts and compares the results of the IGRP metric combiner.
`timescale 1ns / 1ps

module igrp_metric_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  igrp_pkg::t_in                i_in_data,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  igrp_pkg::t_out               i_out_data,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [igrp_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [31:0]                  i_cfg_data,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_routes_seen,
    output int                           o_unreach_seen
);
    import igrp_pkg::*;

    // Local copy of the weight registers.
    logic [7:0]  k_bw, k_load, k_delay, k_rel_off, k_rel_scale;
    logic [31:0] unreach_level;

    t_out expected_routes[$];

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    // Merges the two vectors and works out the composite metric of one route.
    function automatic t_out merge_route(input t_in r);
        t_out        p;
        logic [31:0] m, div;
        p.path_delay       = {1'b0, r.adv_delay};
        p.path_bandwidth   = r.adv_bandwidth;
        p.path_mtu         = r.adv_mtu;
        p.path_reliability = r.adv_reliability;
        p.path_load        = r.adv_load;
        p.path_hops        = r.adv_hops;
        p.unreachable      = 1'b0;
        if (r.iface_present) begin
            p.path_delay     = r.adv_delay + r.iface_delay;
            p.path_bandwidth = (r.adv_bandwidth > r.iface_bandwidth) ?
                               r.adv_bandwidth : r.iface_bandwidth;
            p.path_mtu       = (r.adv_mtu < r.iface_mtu) ? r.adv_mtu : r.iface_mtu;
            if (r.adv_reliability != 0) begin
                p.path_reliability = (r.adv_reliability < r.iface_reliability) ?
                                     r.adv_reliability : r.iface_reliability;
            end else begin
                p.path_reliability = r.iface_reliability;
            end
            if (r.adv_load != 0) begin
                p.path_load = (r.adv_load > r.iface_load) ? r.adv_load : r.iface_load;
            end else begin
                p.path_load = r.iface_load;
            end
            p.path_hops = r.adv_hops + 8'd1;
        end
        m = '0;
        if ({8'd0, r.adv_delay} >= unreach_level) begin
            m = unreach_level;
            p.unreachable = 1'b1;
        end else begin
            if (k_bw != 0) m = m + p.path_bandwidth * k_bw;
            if (k_load != 0) begin
                m = m + (32'(p.path_bandwidth * k_load)) / (32'(LOAD_BASE) - p.path_load);
            end
            if (k_delay != 0) m = m + p.path_delay * k_delay;
            if (k_rel_scale != 0) begin
                div = p.path_reliability + k_rel_off;
                if (div == 0) begin
                    m = unreach_level;
                    p.unreachable = 1'b1;
                end else begin
                    m = (32'(m * k_rel_scale)) / div;
                end
            end
        end
        p.composite_metric = m;
        return p;
    endfunction

    // Watch the three channels at each rising edge.
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            k_bw <= 8'd1; k_load <= 8'd0; k_delay <= 8'd1;
            k_rel_off <= 8'd0; k_rel_scale <= 8'd0; unreach_level <= '1;
            expected_routes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_WEIGHT_BW:    k_bw <= i_cfg_data[7:0];
                    REG_WEIGHT_LOAD:  k_load <= i_cfg_data[7:0];
                    REG_WEIGHT_DELAY: k_delay <= i_cfg_data[7:0];
                    REG_REL_OFFSET:   k_rel_off <= i_cfg_data[7:0];
                    REG_REL_SCALE:    k_rel_scale <= i_cfg_data[7:0];
                    REG_UNREACH:      unreach_level <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) expected_routes.push_back(merge_route(i_in_data));
            if (i_out_valid && i_out_ready) begin
                o_routes_seen++;
                if (i_out_data.unreachable) o_unreach_seen++;
                if (expected_routes.size() == 0) begin
                    report_mismatch("unexpected result", i_out_data.composite_metric, '0);
                end else begin
                    want = expected_routes.pop_front();
                    if (i_out_data.composite_metric !== want.composite_metric)
                        report_mismatch("composite_metric", i_out_data.composite_metric,
                                        want.composite_metric);
                    if (i_out_data.unreachable !== want.unreachable)
                        report_mismatch("unreachable", i_out_data.unreachable,
                                        want.unreachable);
                    if (i_out_data.path_delay !== want.path_delay)
                        report_mismatch("path_delay", i_out_data.path_delay, want.path_delay);
                    if (i_out_data.path_bandwidth !== want.path_bandwidth)
                        report_mismatch("path_bandwidth", i_out_data.path_bandwidth,
                                        want.path_bandwidth);
                    if (i_out_data.path_mtu !== want.path_mtu)
                        report_mismatch("path_mtu", i_out_data.path_mtu, want.path_mtu);
                    if (i_out_data.path_reliability !== want.path_reliability)
                        report_mismatch("path_reliability", i_out_data.path_reliability,
                                        want.path_reliability);
                    if (i_out_data.path_load !== want.path_load)
                        report_mismatch("path_load", i_out_data.path_load, want.path_load);
                    if (i_out_data.path_hops !== want.path_hops)
                        report_mismatch("path_hops", i_out_data.path_hops, want.path_hops);
                end
            end
        end
        o_pending <= expected_routes.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_routes_seen = 0;
        o_unreach_seen = 0;
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: stimulus, configuration phases and verdict for the metric combiner.
`timescale 1ns / 1ps

module tb_top;
    import igrp_pkg::*;

    localparam int DRAIN_CYCLES = 100;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in                  in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out                 out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CfgIdxW-1:0]   cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    int                   fail_count, pending, routes_seen, unreach_seen;
    int                   sent = 0;
    bit                   ready_free = 1'b0;

    always #1 i_clk = ~i_clk;

    igrp_metric_combine_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    igrp_metric_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_routes_seen(routes_seen), .o_unreach_seen(unreach_seen)
    );

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Result-side stalls, except during free-running stretches.
    always @(negedge i_clk) begin
        if (ready_free) out_ready <= 1'b1;
        else out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 9) == 0);
    end

    // Sends one route request and waits for it to be taken. Valid stays high afterwards
    // so that the next request can follow at once; a gap or a drain drops it.
    task automatic send_route(input t_in r, input bit with_gaps);
        int g;
        g = with_gaps ? gap_length() : 0;
        if (g != 0) begin
            in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    // Writes one weight register.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Stops sending, waits until every expected result has come, then lets it settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_weights(input logic [7:0] k1, k2, k3, k4, k5, input logic [31:0] lvl);
        write_reg(REG_WEIGHT_BW, {24'($urandom_range(0, 16777215)), k1});
        write_reg(REG_WEIGHT_LOAD, {24'd0, k2});
        write_reg(REG_WEIGHT_DELAY, {24'd0, k3});
        write_reg(REG_REL_OFFSET, {24'd0, k4});
        write_reg(REG_REL_SCALE, {24'd0, k5});
        write_reg(REG_UNREACH, lvl);
    endtask

    // Random route, biased towards edge values of each field.
    function automatic t_in random_route();
        t_in          r;
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        r = raw[$bits(t_in)-1:0];
        case ($urandom_range(0, 5))
            0: r.adv_delay = '1;
            1: r.adv_delay = 24'($urandom_range(0, 255));
            default: ;
        endcase
        if ($urandom_range(0, 4) == 0) r.adv_reliability = 8'd0;
        if ($urandom_range(0, 4) == 0) r.adv_load = 8'd0;
        if ($urandom_range(0, 5) == 0) r.iface_reliability = 8'd0;
        if ($urandom_range(0, 6) == 0) r.iface_load = 8'hFF;
        if ($urandom_range(0, 6) == 0) r.adv_hops = 8'hFF;
        return r;
    endfunction

    // Directed routes: extremes, both merge rules, the unreachable and zero divisor cases.
    task automatic directed_routes();
        t_in r;
        r = '0;
        send_route(r, 1'b0);
        r = '1;
        send_route(r, 1'b0);
        r.iface_present = 1'b0;
        send_route(r, 1'b0);
        r = '0; r.iface_present = 1'b1; r.iface_reliability = 8'd200; r.iface_load = 8'd9;
        send_route(r, 1'b0);
        r.adv_reliability = 8'd50; r.adv_load = 8'd30; r.adv_hops = 8'hFF;
        r.adv_mtu = 16'd1500; r.iface_mtu = 16'd9000;
        r.adv_bandwidth = 24'd10; r.iface_bandwidth = 24'hFFFFFF;
        r.adv_delay = 24'hFFFFFF; r.iface_delay = 24'hFFFFFF;
        send_route(r, 1'b0);
        r.adv_reliability = 8'hFF; r.iface_reliability = 8'd1;
        r.adv_load = 8'hFF; r.iface_load = 8'd1;
        send_route(r, 1'b0);
        repeat (6) send_route(random_route(), 1'b0);
    endtask

    initial begin
        t_in r;
        int  phase;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset weights first.
        directed_routes();
        drain();

        // Every weight but the reliability offset at full scale, low unreachable level, zero divisor reachable.
        load_weights(8'hFF, 8'hFF, 8'hFF, 8'd0, 8'hFF, 32'd1000);
        directed_routes();
        r = '0; r.adv_delay = 24'd999; r.iface_present = 1'b1;
        send_route(r, 1'b0);
        r.adv_delay = 24'd1000;
        send_route(r, 1'b0);
        drain();

        // All weights but the reliability offset zero, unreachable level zero.
        load_weights(8'd0, 8'd0, 8'd0, 8'hFF, 8'd0, 32'd0);
        directed_routes();
        drain();

        // Random phases with random settings; each phase ends with the sender paused.
        for (phase = 0; phase < 10; phase++) begin
            load_weights(8'($urandom), 8'($urandom), 8'($urandom),
                         ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom),
                         ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom),
                         ($urandom_range(0, 1) == 0) ? 32'hFFFFFFFF : $urandom);
            ready_free = (phase % 3 == 0);
            repeat (110) send_route(random_route(), phase % 3 != 0);
            ready_free = 1'b0;
            drain();
        end

        $display("Sent %0d route requests over 13 weight settings; %0d results checked,",
                 sent, routes_seen);
        $display("%0d of them flagged unreachable.", unreach_seen);
        if (fail_count == 0) begin
            $display("** igrp_metric_combine_core: PASSED **");
        end else begin
            $display("** igrp_metric_combine_core: FAILED **");
        end
        $finish;
    end

    // Overall time limit.
    initial begin
        #2000000;
        $display("Timeout with %0d results outstanding.", pending);
        $display("** igrp_metric_combine_core: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
sv/igrp_pkg.sv
sv/igrp_div.sv
sv/igrp_metric_combine_core.sv
tb/igrp_metric_checker.sv
tb/tb_top.sv
